// ===== rtl/mic_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mic_pkg
// Shared types and constants of the magnetometer iron correction core.
// ----------------------------------------------------------------------------
package mic_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int CEN_W = ((SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16) + 1;
  localparam int PRD_W = 16 + CEN_W;
  localparam int ACC_W = PRD_W + 2;

  localparam int REG_W = 48;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW0   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW2   = 3'd4;

  localparam logic [2:0] FIT_OK     = 3'd0;
  localparam logic [2:0] FIT_FIELD  = 3'd1;
  localparam logic [2:0] FIT_OFFSET = 3'd2;
  localparam logic [2:0] FIT_NOT_PD = 3'd3;
  localparam logic [2:0] FIT_SCALE  = 3'd4;

  localparam logic [14:0] FIELD_MIN = 15'd614;
  localparam logic [14:0] FIELD_MAX = 15'd3277;
  localparam logic [16:0] OFFSET_MAX = 17'd6144;

  // Jacobi working widths: matrix entries, CORDIC vectors, products.
  localparam int AW = 34;
  localparam int CW = 36;
  localparam int PW = AW + CW;
  localparam int GW = CW + 32;
  localparam logic signed [31:0] INV_GAIN = 32'sd652032874;
  localparam logic [4:0] JACOBI_SWEEPS = 5'd24;
  localparam logic [4:0] CORDIC_LAST = 5'd29;
  localparam logic signed [AW+1:0] EIG_MIN = 36'sd4194304;
  localparam logic signed [AW+1:0] EIG_MAX = 36'sd67108864;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] raw_x;
    logic signed [SAMPLE_WIDTH-1:0] raw_y;
    logic signed [SAMPLE_WIDTH-1:0] raw_z;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] corrected_x;
    logic signed [SAMPLE_WIDTH-1:0] corrected_y;
    logic signed [SAMPLE_WIDTH-1:0] corrected_z;
    logic [2:0]                     fit_status;
  } out_word_t;

  typedef struct packed {
    logic [14:0]            field;
    logic [REG_W-1:0]       offset;
    logic [2:0][REG_W-1:0]  rows;
  } cfg_t;

endpackage

// ===== rtl/mic_correct.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mic_correct
// Three-stage correction pipeline: offset subtract, matrix products,
// sum with rounding and saturation.
// ----------------------------------------------------------------------------
module mic_correct
  import mic_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_word_t  in_word,
  input  cfg_t      cfg,
  input  logic [2:0] status,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam logic signed [ACC_W-1:0] RND = ACC_W'(2048);
  localparam logic signed [ACC_W-13:0] SMAX = (ACC_W-12)'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [ACC_W-13:0] SMIN = -SMAX - (ACC_W-12)'(1);

  logic                    v1_r, v2_r, v3_r;
  logic signed [CEN_W-1:0] cen_r [3];
  logic signed [PRD_W-1:0] prd_r [9];
  out_word_t               out_r;

  logic signed [SAMPLE_WIDTH-1:0] raw [3];
  logic signed [SAMPLE_WIDTH-1:0] res [3];
  logic signed [ACC_W-1:0]        acc [3];
  logic signed [ACC_W-13:0]       shf [3];

  always_comb begin
    raw[0] = in_word.raw_x;
    raw[1] = in_word.raw_y;
    raw[2] = in_word.raw_z;
    for (int r = 0; r < 3; r++) begin
      acc[r] = ACC_W'(prd_r[3*r]) + ACC_W'(prd_r[3*r+1]) + ACC_W'(prd_r[3*r+2]) + RND;
      shf[r] = acc[r][ACC_W-1:12];
      if (shf[r] > SMAX) begin
        res[r] = SMAX[SAMPLE_WIDTH-1:0];
      end else if (shf[r] < SMIN) begin
        res[r] = SMIN[SAMPLE_WIDTH-1:0];
      end else begin
        res[r] = shf[r][SAMPLE_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    for (int k = 0; k < 3; k++) begin
      cen_r[k] <= CEN_W'(raw[k]) - CEN_W'($signed(cfg.offset[16*k +: 16]));
    end
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prd_r[3*r+k] <= PRD_W'($signed(cfg.rows[r][16*k +: 16])) * PRD_W'(cen_r[k]);
      end
    end
    out_r.corrected_x <= res[0];
    out_r.corrected_y <= res[1];
    out_r.corrected_z <= res[2];
    out_r.fit_status  <= status;
  end

  assign out_valid = v3_r;
  assign out_word  = out_r;

endmodule

// ===== rtl/mic_fit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mic_fit
// Fit checker: range and symmetry checks, then Jacobi eigenvalues with
// CORDIC-derived rotations, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module mic_fit
  import mic_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       restart,
  input  cfg_t       cfg,
  output logic       busy,
  output logic [2:0] status
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CHECK = 4'd1;
  localparam logic [3:0] ST_PICK  = 4'd2;
  localparam logic [3:0] ST_MAG   = 4'd3;
  localparam logic [3:0] ST_GAIN  = 4'd4;
  localparam logic [3:0] ST_VEC   = 4'd5;
  localparam logic [3:0] ST_MUL   = 4'd6;
  localparam logic [3:0] ST_UPD   = 4'd7;
  localparam logic [3:0] ST_EVAL  = 4'd8;

  localparam logic signed [PW:0] RND30 = (PW+1)'(64'sd536870912);
  localparam logic signed [GW-1:0] RNDG = GW'(64'sd536870912);

  function automatic logic [3:0] idx(input logic [1:0] r, input logic [1:0] k);
    return 4'(r) * 4'd3 + 4'(k);
  endfunction

  logic [3:0]             state_r;
  logic [2:0]             status_r;
  logic signed [AW-1:0]   a_r [9];
  logic [4:0]             sweep_r, step_r;
  logic [1:0]             p_r, q_r;
  logic [2:0]             upd_r;
  logic signed [CW-1:0]   cx_r, cy_r, rc_r, rs_r, xd_r, yd_r;
  logic signed [PW-1:0]   m_ca_r, m_sb_r, m_cb_r, m_sa_r;
  logic [3:0]             wp_r, wq_r;

  // Check stage
  logic [2:0]             chk_code;
  logic                   chk_fail;
  logic signed [16:0]     off;
  logic [16:0]            off_abs;
  // Pivot selection
  logic [AW-1:0]          ab01, ab02, ab12, big;
  logic [1:0]             pp, pq;
  logic signed [CW-1:0]   xdiff, ydbl;
  // Micro-rotations
  logic signed [CW-1:0]   xs, ys, rxs, rys;
  logic                   dir;
  logic signed [GW-1:0]   gprod, gsum;
  logic signed [CW-1:0]   mag, uval;
  // Update
  logic [1:0]             ur;
  logic [3:0]             ip, iq;
  logic signed [PW:0]     sum_p, sum_q;
  // Evaluation
  logic signed [AW+1:0]   mn, mx, d0, d1, d2;

  function automatic logic [AW-1:0] mabs(input logic signed [AW-1:0] v);
    return v[AW-1] ? AW'(-v) : AW'(v);
  endfunction

  always_comb begin
    chk_code = FIT_OK;
    chk_fail = 1'b0;
    off = '0;
    off_abs = '0;
    if (cfg.field < FIELD_MIN || cfg.field > FIELD_MAX) begin
      chk_code = FIT_FIELD;
      chk_fail = 1'b1;
    end
    for (int r = 0; r < 3; r++) begin
      off = 17'($signed(cfg.offset[16*r +: 16]));
      off_abs = off[16] ? 17'(-off) : 17'(off);
      if (!chk_fail) begin
        if (off_abs > OFFSET_MAX) begin
          chk_code = FIT_OFFSET;
          chk_fail = 1'b1;
        end else begin
          for (int k = 0; k < 3; k++) begin
            if (cfg.rows[r][16*k +: 16] != cfg.rows[k][16*r +: 16]) begin
              chk_fail = 1'b1;
            end
          end
          if (chk_fail) begin
            chk_code = FIT_NOT_PD;
          end
        end
      end
    end
  end

  always_comb begin
    ab01 = mabs(a_r[1]);
    ab02 = mabs(a_r[2]);
    ab12 = mabs(a_r[5]);
    big = ab01;
    pp = 2'd0;
    pq = 2'd1;
    if (ab02 > big) begin
      big = ab02;
      pq = 2'd2;
    end
    if (ab12 > big) begin
      big = ab12;
      pp = 2'd1;
      pq = 2'd2;
    end
    xdiff = CW'(a_r[idx(pq, pq)]) - CW'(a_r[idx(pp, pp)]);
    ydbl  = CW'(a_r[idx(pp, pq)]) <<< 1;
  end

  always_comb begin
    xs  = cx_r >>> step_r;
    ys  = cy_r >>> step_r;
    rxs = rc_r >>> step_r;
    rys = rs_r >>> step_r;
    dir = ~cy_r[CW-1];
    gprod = GW'(cx_r) * GW'(INV_GAIN);
    gsum  = gprod + RNDG;
    mag   = gsum[CW+29:30];
    uval  = mag + xd_r;
    if (uval[CW-1]) begin
      uval = '0;
    end
  end

  always_comb begin
    if (upd_r < 3'd3) begin
      ur = upd_r[1:0];
      ip = idx(ur, p_r);
      iq = idx(ur, q_r);
    end else begin
      ur = 2'(upd_r - 3'd3);
      ip = idx(p_r, ur);
      iq = idx(q_r, ur);
    end
    sum_p = (PW+1)'(m_ca_r) - (PW+1)'(m_sb_r) + RND30;
    sum_q = (PW+1)'(m_cb_r) + (PW+1)'(m_sa_r) + RND30;
  end

  always_comb begin
    d0 = (AW+2)'(a_r[0]);
    d1 = (AW+2)'(a_r[4]);
    d2 = (AW+2)'(a_r[8]);
    mn = d0;
    mx = d0;
    if (d1 < mn) mn = d1;
    if (d1 > mx) mx = d1;
    if (d2 < mn) mn = d2;
    if (d2 > mx) mx = d2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CHECK;
      status_r <= FIT_OK;
    end else if (restart) begin
      state_r <= ST_CHECK;
    end else begin
      case (state_r)
        ST_IDLE: begin
          state_r <= ST_IDLE;
        end
        ST_CHECK: begin
          if (chk_fail) begin
            status_r <= chk_code;
            state_r  <= ST_IDLE;
          end else begin
            for (int r = 0; r < 3; r++) begin
              for (int k = 0; k < 3; k++) begin
                a_r[3*r+k] <= AW'($signed(cfg.rows[r][16*k +: 16])) <<< 12;
              end
            end
            sweep_r <= '0;
            state_r <= ST_PICK;
          end
        end
        ST_PICK: begin
          if (sweep_r == JACOBI_SWEEPS || big == '0) begin
            state_r <= ST_EVAL;
          end else begin
            p_r    <= pp;
            q_r    <= pq;
            xd_r   <= xdiff;
            yd_r   <= ydbl;
            cx_r   <= xdiff[CW-1] ? -xdiff : xdiff;
            cy_r   <= ydbl;
            step_r <= '0;
            state_r <= ST_MAG;
          end
        end
        ST_MAG: begin
          if (dir) begin
            cx_r <= cx_r + ys;
            cy_r <= cy_r - xs;
          end else begin
            cx_r <= cx_r - ys;
            cy_r <= cy_r + xs;
          end
          step_r <= step_r + 5'd1;
          if (step_r == CORDIC_LAST) begin
            state_r <= ST_GAIN;
          end
        end
        ST_GAIN: begin
          // The vector (R + x, y) sits at half the rotation angle.
          cx_r   <= uval;
          cy_r   <= yd_r;
          rc_r   <= CW'(INV_GAIN);
          rs_r   <= '0;
          step_r <= '0;
          state_r <= ST_VEC;
        end
        ST_VEC: begin
          // Vectoring and rotation run side by side on the same directions.
          if (dir) begin
            cx_r <= cx_r + ys;
            cy_r <= cy_r - xs;
            rc_r <= rc_r - rys;
            rs_r <= rs_r + rxs;
          end else begin
            cx_r <= cx_r - ys;
            cy_r <= cy_r + xs;
            rc_r <= rc_r + rys;
            rs_r <= rs_r - rxs;
          end
          step_r <= step_r + 5'd1;
          if (step_r == CORDIC_LAST) begin
            upd_r   <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          m_ca_r <= PW'(rc_r) * PW'(a_r[ip]);
          m_sb_r <= PW'(rs_r) * PW'(a_r[iq]);
          m_cb_r <= PW'(rc_r) * PW'(a_r[iq]);
          m_sa_r <= PW'(rs_r) * PW'(a_r[ip]);
          wp_r   <= ip;
          wq_r   <= iq;
          state_r <= ST_UPD;
        end
        ST_UPD: begin
          a_r[wp_r] <= sum_p[AW+29:30];
          a_r[wq_r] <= sum_q[AW+29:30];
          if (upd_r == 3'd5) begin
            sweep_r <= sweep_r + 5'd1;
            state_r <= ST_PICK;
          end else begin
            upd_r   <= upd_r + 3'd1;
            state_r <= ST_MUL;
          end
        end
        ST_EVAL: begin
          if (mn[AW+1] || mn == '0) begin
            status_r <= FIT_NOT_PD;
          end else if (mn < EIG_MIN || mx > EIG_MAX || mx > (mn <<< 2)) begin
            status_r <= FIT_SCALE;
          end else begin
            status_r <= FIT_OK;
          end
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy   = (state_r != ST_IDLE);
  assign status = status_r;

endmodule

// ===== rtl/magnetometer_iron_correction_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_iron_correction_core
// Hard-iron offset removal and soft-iron matrix correction with fit status.
// ----------------------------------------------------------------------------
// A raw sample word is taken on a clock edge with start high and busy low.
// The corrected word appears on out_data with out_valid high for exactly one
// cycle, after the offset, product and sum registers; one word can be taken
// every cycle while busy is low. The receiver cannot stall; words leave in
// acceptance order. Every word carries the fit status of the current
// configuration. That status is computed by a sequential checker: first the
// simple range and symmetry checks, and for a matrix that passes them up to
// 24 Jacobi sweeps, each of two 30-step CORDIC passes and six multiply/update
// pairs. busy is high while it runs. Configuration registers are written
// through cfg_we/cfg_index/cfg_wdata while no word is in flight; the user must
// keep to it; the block does not enforce it. Each write restarts the checker.
// After reset (synchronous, rst_n low) the registers take their defaults, no
// word is in flight, and the checker runs once before busy drops.
// ----------------------------------------------------------------------------
module magnetometer_iron_correction_core
  import mic_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_word_t             in_data,
  output logic                 out_valid,
  output out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata
);

  logic [14:0]      field_r;
  logic [REG_W-1:0] offset_r;
  logic [REG_W-1:0] row_r [3];
  cfg_t             cfg;
  logic             fit_busy;
  logic [2:0]       fit_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r  <= 15'd2048;
      offset_r <= '0;
      row_r[0] <= REG_W'(48'd4096);
      row_r[1] <= REG_W'(48'd4096 << 16);
      row_r[2] <= REG_W'(48'd4096 << 32);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIELD:  field_r  <= cfg_wdata[14:0];
        CFG_OFFSET: offset_r <= cfg_wdata;
        CFG_ROW0:   row_r[0] <= cfg_wdata;
        CFG_ROW1:   row_r[1] <= cfg_wdata;
        CFG_ROW2:   row_r[2] <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.field   = field_r;
    cfg.offset  = offset_r;
    cfg.rows[0] = row_r[0];
    cfg.rows[1] = row_r[1];
    cfg.rows[2] = row_r[2];
  end

  mic_fit u_fit (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (cfg_we),
    .cfg     (cfg),
    .busy    (fit_busy),
    .status  (fit_status)
  );

  mic_correct u_correct (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !fit_busy),
    .in_word   (in_data),
    .cfg       (cfg),
    .status    (fit_status),
    .out_valid (out_valid),
    .out_word  (out_data)
  );

  assign busy = fit_busy;

endmodule
